>>> src/shared_pool_multi_stack_macros.svh
// Assertion macros shared by the shared pool stack modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SHARED_POOL_MULTI_STACK_MACROS_SVH
`define SHARED_POOL_MULTI_STACK_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define SPS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sps_pkg.sv
// Shared types and constants of the shared pool stack block.
// No dependencies; used by the interfaces and every module.
package sps_pkg;

    localparam int NUM_STACKS = 3;
    localparam int KIND_W     = 1;
    localparam int STACK_ID_W = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // item accepted: latch it and read the slot memories
        logic exec;   // update memories and stack tops, load the result
    } sps_cmd_t;

endpackage

>>> src/sps_req_if.sv
// Request channel: one push or pop item per handshake.
// Depends on sps_pkg for field widths.
interface sps_req_if;
    logic                                valid;
    logic                                ready;
    logic [sps_pkg::KIND_W-1:0]          kind;
    logic [sps_pkg::STACK_ID_W-1:0]      stack_id;
    logic signed [sps_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output stack_id, output value, input ready);
    modport sink   (input valid, input kind, input stack_id, input value, output ready);
endinterface

>>> src/sps_rsp_if.sv
// Response channel: one status item per request.
// Depends on sps_pkg for field widths.
interface sps_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sps_pkg::STATUS_W-1:0]        status;
    logic signed [sps_pkg::VALUE_W-1:0]  popped_value;

    modport source (output valid, output status, output popped_value, input ready);
    modport sink   (input valid, input status, input popped_value, output ready);
endinterface

>>> src/sps_ctrl.sv
// Controller of the shared pool stack: two-state sequencer and result valid.
// Depends on sps_pkg and the assertion macro header.
`include "shared_pool_multi_stack_macros.svh"

module sps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sps_pkg::sps_cmd_t cmd
);
    import sps_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Take a new item when idle and the result slot is empty or drains this cycle
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SPS_ASSERT_HOLDS(a_exec_slot_empty, !cmd.exec || !out_valid_reg, "exec with result pending")
    `SPS_ASSERT_NEXT(a_exec_gives_result, cmd.exec, out_valid_reg, "exec did not post a result")
    `SPS_ASSERT_NEXT(a_load_then_exec, cmd.load, cmd.exec && !in_ready, "load not followed by exec")

endmodule

>>> src/sps_dp.sv
// Datapath of the shared pool stack: slot value and link memories, stack
// tops, free list head, fresh slot counter and result register.
// Depends on sps_pkg and the assertion macro header.
`include "shared_pool_multi_stack_macros.svh"

module sps_dp #(
    parameter int POOL_DEPTH = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sps_pkg::sps_cmd_t                   cmd,
    input  logic [sps_pkg::KIND_W-1:0]          in_kind,
    input  logic [sps_pkg::STACK_ID_W-1:0]      in_stack_id,
    input  logic signed [sps_pkg::VALUE_W-1:0]  in_value,
    output logic [sps_pkg::STATUS_W-1:0]        out_status,
    output logic signed [sps_pkg::VALUE_W-1:0]  out_popped_value
);
    import sps_pkg::*;

    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

    // Slot memories
    logic [PTR_W-1:0]   link_mem  [POOL_DEPTH];
    logic [VALUE_W-1:0] value_mem [POOL_DEPTH];

    // Stack tops and free slot bookkeeping
    logic [PTR_W-1:0] top_reg [NUM_STACKS];
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] free_head_next;
    logic [PTR_W-1:0] fresh_reg;
    logic [PTR_W-1:0] fresh_next;

    // Latched item and read data
    kind_t                  kind_reg;
    logic [STACK_ID_W-1:0]  sid_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       link_rd_reg;
    logic [VALUE_W-1:0]     value_rd_reg;

    // Result
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] popped_reg;
    logic [VALUE_W-1:0] popped_next;

    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   top_sel;
    logic               sid_ok;
    logic               top_we;
    logic [PTR_W-1:0]   top_wdata;
    logic               link_we;
    logic               value_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [PTR_W-1:0]   link_wdata;

    // Read address: top of the named stack for a pop, free list head for a push
    always_comb
    begin
        rd_ptr = NULL_PTR;
        if (kind_t'(in_kind) == KIND_POP)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                if (in_stack_id == STACK_ID_W'(i))
                begin
                    rd_ptr = top_reg[i];
                end
            end
        end
        else
        begin
            rd_ptr = free_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(in_kind);
            sid_reg   <= in_stack_id;
            value_reg <= in_value;
            ptr_reg   <= rd_ptr;
            if (rd_ptr != NULL_PTR)
            begin
                link_rd_reg  <= link_mem[rd_ptr[SLOT_W-1:0]];
                value_rd_reg <= value_mem[rd_ptr[SLOT_W-1:0]];
            end
        end
        if (link_we)
        begin
            link_mem[mem_waddr[SLOT_W-1:0]] <= link_wdata;
        end
        if (value_we)
        begin
            value_mem[mem_waddr[SLOT_W-1:0]] <= value_reg;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
    end

    always_comb
    begin
        sid_ok         = (sid_reg < STACK_ID_W'(NUM_STACKS));
        top_sel        = NULL_PTR;
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            if (sid_reg == STACK_ID_W'(i))
            begin
                top_sel = top_reg[i];
            end
        end
        top_we         = 1'b0;
        top_wdata      = NULL_PTR;
        link_we        = 1'b0;
        value_we       = 1'b0;
        mem_waddr      = ptr_reg;
        link_wdata     = top_sel;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        popped_next    = '0;
        if (kind_reg == KIND_PUSH)
        begin
            status_next = ST_FULL;
            if (sid_ok)
            begin
                // Reuse a freed slot first, else claim a never-used one
                if (ptr_reg != NULL_PTR)
                begin
                    mem_waddr      = ptr_reg;
                    free_head_next = link_rd_reg;
                    status_next    = ST_PUSHED;
                end
                else if (fresh_reg < NULL_PTR)
                begin
                    mem_waddr   = fresh_reg;
                    fresh_next  = fresh_reg + PTR_W'(1);
                    status_next = ST_PUSHED;
                end
            end
            if (status_next == ST_PUSHED)
            begin
                link_we    = cmd.exec;
                value_we   = cmd.exec;
                link_wdata = top_sel;
                top_we     = 1'b1;
                top_wdata  = mem_waddr;
            end
        end
        else
        begin
            status_next = ST_EMPTY;
            if (ptr_reg != NULL_PTR)
            begin
                // Unlink the top slot and chain it onto the free list
                popped_next    = value_rd_reg;
                top_we         = 1'b1;
                top_wdata      = link_rd_reg;
                link_we        = cmd.exec;
                mem_waddr      = ptr_reg;
                link_wdata     = free_head_reg;
                free_head_next = ptr_reg;
                status_next    = ST_POPPED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                top_reg[i] <= NULL_PTR;
            end
            free_head_reg <= NULL_PTR;
            fresh_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                if (top_we && sid_reg == STACK_ID_W'(i))
                begin
                    top_reg[i] <= top_wdata;
                end
            end
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
        end
    end

    assign out_status       = status_reg;
    assign out_popped_value = popped_reg;

    `SPS_ASSERT_HOLDS(a_top01_apart, top_reg[0] == NULL_PTR || top_reg[0] != top_reg[1], "stacks 0 and 1 share a top")
    `SPS_ASSERT_HOLDS(a_top12_apart, top_reg[1] == NULL_PTR || top_reg[1] != top_reg[2], "stacks 1 and 2 share a top")
    `SPS_ASSERT_HOLDS(a_top02_apart, top_reg[0] == NULL_PTR || top_reg[0] != top_reg[2], "stacks 0 and 2 share a top")
    `SPS_ASSERT_HOLDS(a_fresh_bound, fresh_reg <= NULL_PTR, "fresh slot count past pool depth")

endmodule

>>> src/shared_pool_multi_stack.sv
// Three LIFO stacks in one shared pool of POOL_DEPTH slots. Each request is a push or a pop on
// stack 0..2 and gives exactly one response. At the accepting edge the slot memories are read
// at the addressed slot (top of stack for a pop, head of the free list for a push); at the
// next edge the link and value memories and the stack tops are updated and the response
// register is loaded. The next request is accepted in the cycle the response is taken, and
// no new request is accepted while an item is being executed. Freed slots are chained into a
// free list and never-used slots are handed out by a counter, so no clearing pass follows
// reset and requests are taken from the first cycle.
module shared_pool_multi_stack #(
    parameter int POOL_DEPTH = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    sps_req_if.sink    req,
    sps_rsp_if.source  rsp
);
    import sps_pkg::*;

    sps_cmd_t cmd;

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sps_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .in_kind          (req.kind),
        .in_stack_id      (req.stack_id),
        .in_value         (req.value),
        .out_status       (rsp.status),
        .out_popped_value (rsp.popped_value)
    );

endmodule
